// ===== design/oash_pkg.sv =====
// Shared constants, status codes and sizes for the open-addressing hash table.
`timescale 1ns / 1ps
package oash_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int MAX_KEY_LEN = 16;
  localparam int MAX_PROBE   = 31;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int SIZE_W  = 10;
  localparam int KPOS_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_KEY_LEN + 1);
  localparam int SUM_W   = $clog2(MAX_KEY_LEN * 255 + 1);
  localparam int PRB_W   = $clog2(MAX_PROBE + 1);
  localparam int BC_W    = $clog2(SUM_W);
  localparam int VAL_W   = 32;
  localparam int KEY_W   = 8 * MAX_KEY_LEN;
  localparam int ROW_W   = KEY_W + VAL_W + CNT_W + 1;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== design/open_addressing_string_hash_table.sv =====
// Open-addressing hash table for short byte-string keys with 32-bit values.
//
// Input stream: one key byte per transaction. in_tdata = {value_word, key_byte}
// (key_byte lowest), in_tuser = mode (0 insert/update, 1 lookup), in_tlast marks
// the final byte. Only mode and value_word on the final byte count.
// Output stream: one transaction per key, out_tdata = {found_value, status}.
// Config: cfg_we writes cfg_wdata into table_size (0 acts as 1, above 512 as 512).
//
// Non-final bytes are buffered and summed. The final byte starts a sequencer around
// one shared compare-and-subtract unit: sum mod size, then odd-count mod size,
// then per probe: advance index, read slot row, compare; up to 31 probes, then
// the result register is loaded.
// in_tready stays low until the result is loaded. A too-long key skips to
// loading its result.
// After reset a clearing pass writes every slot empty, with in_tready
// low. A stalled receiver holds the result register; the next key is still
// taken and processed, then waits in its sequencer with in_tready low.
`timescale 1ns / 1ps
module open_addressing_string_hash_table
  import oash_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // [7:0] key_byte, [39:8] value_word
  input  logic                 in_tlast,
  input  logic                 in_tuser,   // [0] mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [2:0] status, [34:3] found_value
  input  logic                 cfg_we,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MODS  = 3'd1;
  localparam logic [2:0] S_MODO  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] tsize_r;
  logic [SIZE_W-1:0] size_eff;
  logic              clearing_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  logic [7:0]        kbuf_r [MAX_KEY_LEN];
  logic [KEY_W-1:0]  kvec;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  odd_r, odd_nxt;
  logic              ovf_r, ovf_nxt;
  logic              mode_r, mode_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;

  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [SIZE_W-1:0] oddm_r, oddm_nxt;
  logic [SIZE_W-1:0] h_r, h_nxt;
  logic [PRB_W-1:0]  a_r, a_nxt;
  logic [2:0]        stat_r, stat_nxt;
  logic [VAL_W-1:0]  found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_stat_r, out_stat_nxt;
  logic [VAL_W-1:0]  out_found_r, out_found_nxt;

  // Shared compare-and-subtract unit
  logic [SIZE_W:0]   u_a, u_y;

  row_t              mem [TABLE_DEPTH];
  row_t              rd_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr;
  row_t              mem_wdata;

  logic              acc;
  logic              row_valid, row_match;
  logic [CNT_W-1:0]  row_len;
  logic              bytes_eq;

  assign in_tready  = (state_r == S_IDLE) && !clearing_r;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(40 - VAL_W - 3){1'b0}}, out_found_r, out_stat_r};

  // Clamp the table size into 1..TABLE_DEPTH
  always_comb begin
    if (tsize_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (tsize_r > SIZE_W'(TABLE_DEPTH)) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = tsize_r;
    end
  end

  always_comb begin
    if (state_r == S_STEP) begin
      u_a = {1'b0, h_r} + {1'b0, oddm_r};
    end else begin
      u_a = {rem_r, dvd_r[SUM_W-1]};
    end
    u_y = (u_a >= {1'b0, size_eff}) ? (u_a - {1'b0, size_eff}) : u_a;
  end

  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      kvec[8*i +: 8] = kbuf_r[i];
    end
  end

  // Compare the stored row against the buffered key, bytes below the length only
  assign row_valid = rd_r[ROW_W-1];
  assign row_len   = rd_r[KEY_W+VAL_W +: CNT_W];
  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if ((CNT_W'(i) < cnt_r) && (rd_r[8*i +: 8] != kbuf_r[i])) begin
        bytes_eq = 1'b0;
      end
    end
  end
  assign row_match = row_valid && (row_len == cnt_r) && bytes_eq;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    odd_nxt       = odd_r;
    ovf_nxt       = ovf_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bc_nxt        = bc_r;
    oddm_nxt      = oddm_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    stat_nxt      = stat_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_found_nxt = out_found_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (clearing_r) begin
      mem_we = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (cnt_r < CNT_W'(MAX_KEY_LEN)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_r + SUM_W'(in_tdata[7:0]);
            odd_nxt = odd_r + CNT_W'(in_tdata[0]);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            mode_nxt  = in_tuser;
            val_nxt   = in_tdata[39:8];
            found_nxt = '0;
            if (ovf_nxt) begin
              stat_nxt  = ST_TOO_LONG;
              state_nxt = S_RES;
            end else begin
              dvd_nxt   = sum_nxt;
              rem_nxt   = '0;
              bc_nxt    = '0;
              state_nxt = S_MODS;
            end
          end
        end
      end
      S_MODS, S_MODO: begin
        rem_nxt = u_y[SIZE_W-1:0];
        dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        bc_nxt  = bc_r + BC_W'(1);
        if (bc_r == BC_W'(SUM_W - 1)) begin
          if (state_r == S_MODS) begin
            h_nxt     = u_y[SIZE_W-1:0];
            dvd_nxt   = SUM_W'(odd_r);
            rem_nxt   = '0;
            bc_nxt    = '0;
            state_nxt = S_MODO;
          end else begin
            oddm_nxt  = u_y[SIZE_W-1:0];
            a_nxt     = '0;
            stat_nxt  = mode_r ? ST_MISS : ST_FULL;
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        h_nxt     = u_y[SIZE_W-1:0];
        a_nxt     = a_r + PRB_W'(1);
        state_nxt = S_READ;
      end
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        mem_waddr = h_r[IDX_W-1:0];
        if (row_match) begin
          if (mode_r) begin
            stat_nxt  = ST_HIT;
            found_nxt = rd_r[KEY_W +: VAL_W];
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_r;
            mem_wdata[KEY_W +: VAL_W] = val_r;
            stat_nxt  = ST_UPDATED;
          end
          state_nxt = S_RES;
        end else if (!row_valid) begin
          if (mode_r) begin
            stat_nxt = ST_MISS;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, cnt_r, val_r, kvec};
            stat_nxt  = ST_INSERTED;
          end
          state_nxt = S_RES;
        end else if (a_r == PRB_W'(MAX_PROBE)) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_RES: begin
        // Hold here until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_found_nxt = found_r;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          odd_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[h_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (cnt_r < CNT_W'(MAX_KEY_LEN))) begin
      kbuf_r[cnt_r[KPOS_W-1:0]] <= in_tdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tsize_r     <= SIZE_W'(TABLE_DEPTH);
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      odd_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        tsize_r <= cfg_wdata;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      odd_r       <= odd_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    val_r       <= val_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    bc_r        <= bc_nxt;
    oddm_r      <= oddm_nxt;
    h_r         <= h_nxt;
    a_r         <= a_nxt;
    stat_r      <= stat_nxt;
    found_r     <= found_nxt;
    out_stat_r  <= out_stat_nxt;
    out_found_r <= out_found_nxt;
  end

  // No input taken while the table is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input accepted during clearing pass");

  // Probe index stays inside the table in use
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (h_r < size_eff))
    else $error("probe index out of range");

  // Probe count never passes the limit
  a_probe_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (a_r <= PRB_W'(MAX_PROBE)))
    else $error("too many probes");

  // A loaded result carries a nonzero found value only on a hit
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != ST_HIT)) |-> (out_found_r == '0))
    else $error("nonzero found value without hit");

endmodule

// ===== tb/sv/oash_checker.sv =====
// Scoreboard for the hash table: watches both streams, predicts each status and compares.
`timescale 1ns / 1ps
module oash_checker
  import oash_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [39:0]       in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [39:0]       out_tdata,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } lookup_result_t;

  bit             slot_used [TABLE_DEPTH];
  logic [7:0]     slot_key  [TABLE_DEPTH][MAX_KEY_LEN];
  int             slot_len  [TABLE_DEPTH];
  logic [31:0]    slot_val  [TABLE_DEPTH];
  logic [7:0]     key_buf   [MAX_KEY_LEN];
  int             nbytes, byte_sum, odd_cnt;
  bit             too_long;
  int             size_reg;
  lookup_result_t status_q [$];

  function automatic bit key_matches(int idx);
    if (!slot_used[idx] || slot_len[idx] != nbytes) return 0;
    for (int i = 0; i < nbytes; i++)
      if (slot_key[idx][i] != key_buf[i]) return 0;
    return 1;
  endfunction

  // Absorb one key byte; on the last one resolve the probe chain.
  task automatic absorb_byte(logic mode, logic [7:0] b, logic last, logic [31:0] val);
    int             eff;
    int             idx;
    lookup_result_t res;
    if (nbytes < MAX_KEY_LEN) begin
      key_buf[nbytes] = b;
      nbytes++;
      byte_sum += b;
      odd_cnt += b[0];
    end else begin
      too_long = 1;
    end
    if (!last) return;
    eff = (size_reg == 0) ? 1 : (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
    res.status = mode ? ST_MISS : ST_FULL;
    res.value = '0;
    if (too_long) begin
      res.status = ST_TOO_LONG;
    end else begin
      for (int a = 1; a <= MAX_PROBE; a++) begin
        idx = (byte_sum + a * odd_cnt) % eff;
        if (key_matches(idx)) begin
          if (mode) begin
            res.status = ST_HIT;
            res.value = slot_val[idx];
          end else begin
            slot_val[idx] = val;
            res.status = ST_UPDATED;
          end
          break;
        end
        if (!slot_used[idx]) begin
          if (mode) begin
            res.status = ST_MISS;
          end else begin
            slot_used[idx] = 1;
            slot_len[idx] = nbytes;
            for (int i = 0; i < nbytes; i++) slot_key[idx][i] = key_buf[i];
            slot_val[idx] = val;
            res.status = ST_INSERTED;
          end
          break;
        end
      end
    end
    status_q.push_back(res);
    nbytes = 0;
    byte_sum = 0;
    odd_cnt = 0;
    too_long = 0;
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 0;
      nbytes = 0;
      byte_sum = 0;
      odd_cnt = 0;
      too_long = 0;
      size_reg = 512;
      fail_count = 0;
      status_q.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (in_tvalid && in_tready)
        absorb_byte(in_tuser, in_tdata[7:0], in_tlast, in_tdata[39:8]);
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result status=%0d value=%h",
                     out_tdata[2:0], out_tdata[34:3]);
        end else begin
          exp_r = status_q.pop_front();
          if (out_tdata[2:0] !== exp_r.status || out_tdata[34:3] !== exp_r.value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: status exp=%0d got=%0d, value exp=%h got=%h",
                       exp_r.status, out_tdata[2:0], exp_r.value, out_tdata[34:3]);
          end
        end
      end
    end
    pending = status_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives key streams and table sizes into the hash table and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import oash_pkg::*;

  localparam int KEY_ROOM = MAX_KEY_LEN + 4;   // room for keys that overflow
  localparam int POOL_N   = 40;
  localparam int SETTLE   = 150;               // worst-case key latency plus margin

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;    // [7:0] key_byte, [39:8] value_word
  logic              in_tlast = 0;
  logic              in_tuser = 0;     // [0] mode
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [39:0]       out_tdata;        // [2:0] status, [34:3] found_value
  logic              cfg_we = 0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  int  fail_count, pending;
  bit  quiet = 0;       // no idling on either side
  bit  hold_req = 0;    // ask the receiver for one long hold-off
  int  bytes_sent = 0, keys_sent = 0;

  logic [7:0] pool_key [POOL_N][KEY_ROOM];
  int         pool_len [POOL_N];
  logic [7:0] cur_key  [KEY_ROOM];

  open_addressing_string_hash_table u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_wdata
  );

  oash_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_wdata,
    .fail_count, .pending
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 0;
        for (int n = 0; n < 600; n++) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Present one byte and hold it until the transaction completes.
  task automatic send_byte(logic mode, logic [7:0] b, logic last, logic [31:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {val, b};
    in_tlast  <= last;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Stream cur_key; mode and value on earlier bytes are random noise.
  task automatic send_key(int len, logic mode, logic [31:0] val);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1) send_byte(mode, cur_key[i], 1, val);
      else              send_byte($urandom_range(0, 1), cur_key[i], 0, $urandom);
    end
    keys_sent++;
  endtask

  // Wait until every result is back and the sequencer has settled.
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] v);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
  endtask

  task automatic make_key(int len, bit even_only);
    for (int i = 0; i < len; i++) begin
      cur_key[i] = $urandom;
      if (even_only) cur_key[i][0] = 0;
    end
  endtask

  task automatic fill_pool();
    for (int p = 0; p < POOL_N; p++) begin
      pool_len[p] = ($urandom_range(0, 7) == 0) ? MAX_KEY_LEN : $urandom_range(1, 6);
      make_key(pool_len[p], $urandom_range(0, 9) == 0);
      for (int i = 0; i < pool_len[p]; i++) pool_key[p][i] = cur_key[i];
    end
  endtask

  // One phase of random traffic: mostly pool keys so hits and updates occur.
  task automatic random_phase(int n_bytes);
    int start, p, len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(0, 19))
        0: begin
          len = $urandom_range(MAX_KEY_LEN + 1, KEY_ROOM);
          make_key(len, 0);
        end
        1, 2, 3: begin
          len = $urandom_range(1, MAX_KEY_LEN);
          make_key(len, $urandom_range(0, 3) == 0);
        end
        default: begin
          p = $urandom_range(0, POOL_N - 1);
          len = pool_len[p];
          for (int i = 0; i < len; i++) cur_key[i] = pool_key[p][i];
        end
      endcase
      send_key(len, $urandom_range(0, 1), $urandom);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [8];
    sizes = '{10'd1, 10'd0, 10'd7, 10'd1023, 10'd600, 10'd37, 10'd2, 10'd512};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    set_size(10'd512);

    // Directed: extreme bytes, update, hit, miss, overflow, zero odd count.
    cur_key[0] = 8'h00;
    send_key(1, 0, 32'h0000_0000);
    send_key(1, 1, 32'hFFFF_FFFF);
    cur_key[0] = 8'hFF;
    send_key(1, 1, 32'h1234_5678);
    send_key(1, 0, 32'hFFFF_FFFF);
    send_key(1, 0, 32'hA5A5_5A5A);
    send_key(1, 1, 32'h0);
    make_key(MAX_KEY_LEN, 0);
    send_key(MAX_KEY_LEN, 0, 32'hDEAD_BEEF);
    send_key(MAX_KEY_LEN, 1, 32'h0);
    make_key(MAX_KEY_LEN + 1, 0);
    send_key(MAX_KEY_LEN + 1, 0, 32'h5555_AAAA);
    // Even bytes only: every probe lands on the same slot.
    cur_key[0] = 8'h02; cur_key[1] = 8'h04;
    send_key(2, 0, 32'h0000_0001);
    cur_key[0] = 8'h04; cur_key[1] = 8'h02;
    send_key(2, 0, 32'h0000_0002);
    send_key(2, 1, 32'h0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_size(sizes[ph]);
      fill_pool();
      if (ph == 3) hold_req = 1;    // block fills up and backs up its input
      if (ph == 7) quiet = 1;
      random_phase(240);
      drain();
    end

    $display("Run covered %0d key bytes in %0d keys over 8 table sizes (0, 1, 2, 1023 among them),",
             bytes_sent, keys_sent);
    $display("with inserts, updates, hits, misses, full-table and overlong keys.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
